// ----- rtl/sweep_residual_convergence_check_top_assert.svh -----
// Assertion macros shared by the sweep residual convergence check RTL.
`ifndef SWEEP_RESIDUAL_CONVERGENCE_CHECK_TOP_ASSERT_SVH
`define SWEEP_RESIDUAL_CONVERGENCE_CHECK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srcc: same-cycle check failed");
`define SRCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srcc: next-cycle check failed");
`else
`define SRCC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SRCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/srcc_pkg.sv -----
// Package: constants, codes and beat types of the sweep residual convergence check.
`default_nettype none
package srcc_pkg;

   localparam int GRID_POINTS    = 4096;
   localparam int SAMPLE_BITS    = 24;
   localparam int POS_BITS       = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
   localparam int DIFF_BITS      = SAMPLE_BITS + 1;
   localparam int SQ_BITS        = 2 * DIFF_BITS;
   localparam int SUM_BITS       = 64;
   localparam int COUNT_BITS     = 20;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 1;

   localparam int Q_DEPTH        = 4;
   localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);
   localparam int OUT_DEPTH      = 8;
   localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

   localparam logic [POS_BITS-1:0]   POS_LAST          = POS_BITS'(GRID_POINTS - 1);
   localparam logic [COUNT_BITS-1:0] SWEEP_LIMIT_RESET = COUNT_BITS'(1000);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX         = '1;
   localparam logic [SUM_BITS-1:0]   SUM_ALL_ONES      = '1;
   localparam logic [SUM_BITS-1:0]   SQ_SAT_BOUND      = SUM_BITS'(64'hFFFF_FFFF);

   typedef enum logic [0:0] {
      OP_SAMPLE  = 1'b0,
      OP_RESTART = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOLERANCE_SQUARED = 1'b0,
      CSR_SWEEP_LIMIT       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic restart;
      logic last;
      logic first_sweep;
   } tag_type;

   typedef struct packed {
      tag_type                       tag;
      logic [POS_BITS-1:0]           pos;
      logic signed [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } item_beat_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]   residual_squared;
      logic [COUNT_BITS-1:0] sweep_count;
      logic                  converged;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/srcc_front.sv -----
// Front end: takes input beats, classifies them and tags grid position and first sweep.
`default_nettype none
module srcc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  srcc_pkg::opcode_type                 req_opcode,
   input  logic signed [srcc_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                 req_last_in_sweep,
   input  logic                                 q_full,
   output logic                                 full,
   output srcc_pkg::item_beat_type              beat_out
);
   import srcc_pkg::*;

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                have_prev_ff, have_prev_in;
   logic                accept;
   logic                is_restart;

   assign full       = q_full;
   assign accept     = push & ~q_full;
   assign is_restart = (req_opcode == OP_RESTART);

   always_comb begin
      pos_in                         = pos_ff;
      have_prev_in                   = have_prev_ff;
      beat_out.valid                 = accept;
      beat_out.item.tag.restart      = is_restart;
      beat_out.item.tag.last         = req_last_in_sweep;
      beat_out.item.tag.first_sweep  = ~have_prev_ff;
      beat_out.item.pos              = pos_ff;
      beat_out.item.sample           = req_sample_value;
      if (accept) begin
         if (is_restart) begin
            pos_in       = '0;
            have_prev_in = 1'b0;
         end else if (req_last_in_sweep) begin
            pos_in       = '0;
            have_prev_in = 1'b1;
         end else begin
            pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/srcc_item_queue.sv -----
// Short queue of classified beats between front and back end.
`default_nettype none
`include "sweep_residual_convergence_check_top_assert.svh"
module srcc_item_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  srcc_pkg::item_beat_type wr_beat,
   input  logic                    rd_pop,
   output srcc_pkg::item_beat_type rd_beat,
   output logic                    full
);
   import srcc_pkg::*;

   item_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full          = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign rd_beat.valid = (count_ff != '0);
   assign rd_beat.item  = slot_ff[rd_ptr_ff];
   assign do_push       = wr_beat.valid;
   assign do_pop        = rd_pop & rd_beat.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_beat.item;
      end
   end

   `SRCC_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, wr_beat.valid, count_ff < Q_CNT_BITS'(Q_DEPTH))

endmodule
`default_nettype wire

// ----- rtl/srcc_back.sv -----
// Back end: grid store, difference, square, saturating sum and result buffer.
`default_nettype none
`include "sweep_residual_convergence_check_top_assert.svh"
module srcc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  srcc_pkg::item_beat_type             q_beat,
   output logic                                q_pop,
   input  logic [srcc_pkg::SUM_BITS-1:0]       tolerance_squared,
   input  logic [srcc_pkg::COUNT_BITS-1:0]     sweep_limit,
   input  logic                                pop,
   output logic                                empty,
   output srcc_pkg::result_type                result
);
   import srcc_pkg::*;

   // grid store, read-first so a beat sees the value of the previous sweep
   logic [SAMPLE_BITS-1:0]        grid_mem [GRID_POINTS];
   // entries at or above the fill count were not written since restart and read as zero
   logic [POS_BITS:0]             fill_ff, fill_in;

   // stage 1: store read data
   logic                          s1_valid_ff;
   tag_type                       s1_tag_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic                          prev_known_ff;
   logic signed [SAMPLE_BITS-1:0] prev_val;
   // stage 2: magnitude of difference
   logic                          s2_valid_ff;
   tag_type                       s2_tag_ff;
   logic [DIFF_BITS-1:0]          mag_ff, mag_in;
   // stage 3: square
   logic                          s3_valid_ff;
   tag_type                       s3_tag_ff;
   logic [SUM_BITS-1:0]           sq_ff, sq_in;

   logic signed [DIFF_BITS-1:0]   diff;
   logic [SQ_BITS-1:0]            prod;
   logic [SUM_BITS:0]             sum_add;
   logic [SUM_BITS-1:0]           sum_sat, acc;
   logic [SUM_BITS-1:0]           sum_ff, sum_in;
   logic [COUNT_BITS-1:0]         sweeps_ff, sweeps_in, sweeps_inc;
   result_type                    res_in;
   logic                          out_push, out_pop;
   logic [OUT_CNT_BITS:0]         room_used;

   result_type                    out_slot_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]       out_wr_ptr_ff, out_rd_ptr_ff;
   logic [OUT_CNT_BITS-1:0]       out_count_ff, out_count_in;

   // results still in flight must find room in the buffer
   assign room_used = {1'b0, out_count_ff}
                    + (OUT_CNT_BITS+1)'(s1_valid_ff & s1_tag_ff.last & ~s1_tag_ff.restart)
                    + (OUT_CNT_BITS+1)'(s2_valid_ff & s2_tag_ff.last & ~s2_tag_ff.restart)
                    + (OUT_CNT_BITS+1)'(s3_valid_ff & s3_tag_ff.last & ~s3_tag_ff.restart);
   assign q_pop     = q_beat.valid && (room_used < (OUT_CNT_BITS+1)'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (!q_beat.item.tag.restart) begin
            grid_mem[q_beat.item.pos] <= q_beat.item.sample;
         end
         prev_ff       <= grid_mem[q_beat.item.pos];
         prev_known_ff <= ({1'b0, q_beat.item.pos} < fill_ff);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (q_pop) begin
         if (q_beat.item.tag.restart) begin
            fill_in = '0;
         end else if ({1'b0, q_beat.item.pos} >= fill_ff) begin
            fill_in = {1'b0, q_beat.item.pos} + 1'b1;
         end
      end
   end

   always_comb begin
      prev_val = prev_known_ff ? prev_ff : '0;
      diff   = DIFF_BITS'(s1_sample_ff) - DIFF_BITS'(prev_val);
      mag_in = diff[DIFF_BITS-1] ? unsigned'(-diff) : unsigned'(diff);
      prod   = SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);
      sq_in  = (SUM_BITS'(mag_ff) > SQ_SAT_BOUND) ? SUM_ALL_ONES : SUM_BITS'(prod);
   end

   always_comb begin
      sum_add    = {1'b0, sum_ff} + {1'b0, sq_ff};
      sum_sat    = sum_add[SUM_BITS] ? SUM_ALL_ONES : sum_add[SUM_BITS-1:0];
      acc        = s3_tag_ff.first_sweep ? sum_ff : sum_sat;
      sweeps_inc = (sweeps_ff == COUNT_MAX) ? sweeps_ff : sweeps_ff + 1'b1;
      res_in.residual_squared = s3_tag_ff.first_sweep ? SUM_ALL_ONES : acc;
      res_in.sweep_count      = sweeps_inc;
      res_in.converged        = (!s3_tag_ff.first_sweep && (acc < tolerance_squared))
                              || (sweeps_inc >= sweep_limit);
      out_push  = s3_valid_ff && !s3_tag_ff.restart && s3_tag_ff.last;
      sum_in    = sum_ff;
      sweeps_in = sweeps_ff;
      if (s3_valid_ff) begin
         if (s3_tag_ff.restart) begin
            sum_in    = '0;
            sweeps_in = '0;
         end else if (s3_tag_ff.last) begin
            sum_in    = '0;
            sweeps_in = sweeps_inc;
         end else begin
            sum_in = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
         sweeps_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         sum_ff      <= sum_in;
         sweeps_ff   <= sweeps_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff    <= q_beat.item.tag;
      s1_sample_ff <= q_beat.item.sample;
      s2_tag_ff    <= s1_tag_ff;
      mag_ff       <= mag_in;
      s3_tag_ff    <= s2_tag_ff;
      sq_ff        <= sq_in;
   end

   // result buffer
   assign empty   = (out_count_ff == '0);
   assign out_pop = pop & ~empty;
   assign result  = out_slot_ff[out_rd_ptr_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         out_count_ff <= out_count_in;
         if (out_push) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_slot_ff[out_wr_ptr_ff] <= res_in;
      end
   end

   `SRCC_ASSERT_IMPLY(a_result_room, clock, reset, out_push, out_count_ff < OUT_CNT_BITS'(OUT_DEPTH))
   `SRCC_ASSERT_NEXT(a_restart_clears, clock, reset, s3_valid_ff && s3_tag_ff.restart, sweeps_ff == '0 && sum_ff == '0)
   `SRCC_ASSERT_IMPLY(a_first_sweep_no_sum, clock, reset, s3_valid_ff && s3_tag_ff.first_sweep, sum_ff == '0)
   `SRCC_ASSERT_NEXT(a_sweep_count_step, clock, reset, out_push && sweeps_ff != COUNT_MAX, sweeps_ff == $past(sweeps_ff) + 1'b1)

endmodule
`default_nettype wire

// ----- rtl/sweep_residual_convergence_check_top.sv -----
// Top level: configuration registers and the front, queue and back end.
//
//  channel   ports                                         beat moves when
//  request   push/full, req_opcode, req_sample_value,      push & !full
//            req_last_in_sweep
//  response  empty/pop, rsp_residual_squared,              pop & !empty
//            rsp_sweep_count, rsp_converged
//  config    csr_we, csr_index, csr_wdata                  csr_we
//
// One beat per cycle while the result buffer has room; the grid store is read and written at
// the same port per beat. A result passes stages 1 to 3 and waits in the result buffer to pop.
// Reset and restart clear control only; a fill count makes entries not written since read as 0.
// full rises when the four-entry queue fills, i.e. once the eight-entry result buffer
// plus results in flight are full and the consumer stalls.
`default_nettype none
module sweep_residual_convergence_check_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  srcc_pkg::opcode_type                    req_opcode,
   input  logic signed [srcc_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                    req_last_in_sweep,
   output logic                                    empty,
   input  logic                                    pop,
   output logic [srcc_pkg::SUM_BITS-1:0]           rsp_residual_squared,
   output logic [srcc_pkg::COUNT_BITS-1:0]         rsp_sweep_count,
   output logic                                    rsp_converged,
   input  logic                                    csr_we,
   input  logic [srcc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [srcc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import srcc_pkg::*;

   logic [SUM_BITS-1:0]   tolerance_ff, tolerance_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   item_beat_type         front_beat, queue_beat;
   logic                  q_full, q_pop;
   result_type            result;

   always_comb begin
      tolerance_in = tolerance_ff;
      limit_in     = limit_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOLERANCE_SQUARED: tolerance_in = csr_wdata[SUM_BITS-1:0];
            CSR_SWEEP_LIMIT:       limit_in     = csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
         limit_ff     <= SWEEP_LIMIT_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
         limit_ff     <= limit_in;
      end
   end

   srcc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .req_opcode        (req_opcode),
      .req_sample_value  (req_sample_value),
      .req_last_in_sweep (req_last_in_sweep),
      .q_full            (q_full),
      .full              (full),
      .beat_out          (front_beat)
   );

   srcc_item_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_beat (front_beat),
      .rd_pop  (q_pop),
      .rd_beat (queue_beat),
      .full    (q_full)
   );

   srcc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_beat            (queue_beat),
      .q_pop             (q_pop),
      .tolerance_squared (tolerance_ff),
      .sweep_limit       (limit_ff),
      .pop               (pop),
      .empty             (empty),
      .result            (result)
   );

   assign rsp_residual_squared = result.residual_squared;
   assign rsp_sweep_count      = result.sweep_count;
   assign rsp_converged        = result.converged;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for the sweep residual convergence check: directed plan, random sweeps, full-scale swings.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import srcc_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_BEATS  = 1500;
   localparam int PLAN_ROWS     = 24;
   localparam int SWING_POINTS  = 64;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam result_type NO_RESULT = '0;

   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      opcode_type                op;
      logic [SAMPLE_BITS-1:0]    sample;
      logic                      last;
      logic                      typed;
      result_type                want;
      csr_index_type             idx;
      logic [CSR_DATA_BITS-1:0]  data;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   opcode_type                    req_opcode = OP_SAMPLE;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                          req_last_in_sweep = 1'b0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic [SUM_BITS-1:0]           rsp_residual_squared;
   logic [COUNT_BITS-1:0]         rsp_sweep_count;
   logic                          rsp_converged;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   sweep_residual_convergence_check_top dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_opcode           (req_opcode),
      .req_sample_value     (req_sample_value),
      .req_last_in_sweep    (req_last_in_sweep),
      .empty                (empty),
      .pop                  (pop),
      .rsp_residual_squared (rsp_residual_squared),
      .rsp_sweep_count      (rsp_sweep_count),
      .rsp_converged        (rsp_converged),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic signed [SAMPLE_BITS-1:0] stored_grid [GRID_POINTS];
   int                            grid_pos = 0;
   int                            filled_span = 0;
   logic [SUM_BITS-1:0]           run_sum = '0;
   logic [COUNT_BITS-1:0]         sweeps_seen = '0;
   bit                            have_prev = 1'b0;
   logic [SUM_BITS-1:0]           tol_sq = '0;
   logic [COUNT_BITS-1:0]         limit_reg = SWEEP_LIMIT_RESET;

   result_type residuals_due [$];
   int         mismatches = 0;
   int         idle_cycles = 0;
   int         hold = 0;
   bit         calm = 1'b0;
   row_type    plan [PLAN_ROWS];

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic absorb_sample(input opcode_type op, input logic signed [SAMPLE_BITS-1:0] s,
                                input bit lst, output bit has, output result_type r);
      logic [SAMPLE_BITS:0] diff;
      logic [SAMPLE_BITS:0] mag;
      logic [SUM_BITS-1:0]  sq;
      logic [SUM_BITS:0]    total;
      logic [SAMPLE_BITS-1:0] prev;
      has = 1'b0;
      r = '0;
      if (op == OP_RESTART) begin
         foreach (stored_grid[i]) stored_grid[i] = '0;
         grid_pos = 0;
         filled_span = 0;
         run_sum = '0;
         sweeps_seen = '0;
         have_prev = 1'b0;
         return;
      end
      if (have_prev) begin
         prev = stored_grid[grid_pos];
         diff = {s[SAMPLE_BITS-1], s} - {prev[SAMPLE_BITS-1], prev};
         mag = diff[SAMPLE_BITS] ? -diff : diff;
         sq = SUM_BITS'(mag) * SUM_BITS'(mag);
         total = {1'b0, run_sum} + {1'b0, sq};
         run_sum = total[SUM_BITS] ? SUM_ALL_ONES : total[SUM_BITS-1:0];
      end
      stored_grid[grid_pos] = s;
      if (grid_pos + 1 > filled_span) filled_span = grid_pos + 1;
      grid_pos = (grid_pos + 1) % GRID_POINTS;
      if (!lst) return;
      if (sweeps_seen != COUNT_MAX) sweeps_seen++;
      r.residual_squared = have_prev ? run_sum : SUM_ALL_ONES;
      r.sweep_count = sweeps_seen;
      r.converged = (have_prev && run_sum < tol_sq) || (sweeps_seen >= limit_reg);
      has = 1'b1;
      have_prev = 1'b1;
      run_sum = '0;
      grid_pos = 0;
   endtask

   task automatic send_beat(input opcode_type op, input logic signed [SAMPLE_BITS-1:0] s,
                            input bit lst, input bit typed, input result_type want);
      bit         has;
      result_type got;
      int         gap;
      push <= 1'b1;
      req_opcode <= op;
      req_sample_value <= s;
      req_last_in_sweep <= lst;
      @(posedge clock);
      while (full) @(posedge clock);
      absorb_sample(op, s, lst, has, got);
      if (has) residuals_due.push_back(typed ? want : got);
      gap = pick_gap();
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      push <= 1'b0;
      while (residuals_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TOLERANCE_SQUARED: tol_sq = data;
         CSR_SWEEP_LIMIT:       limit_reg = data[COUNT_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: random stalls, then field compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         hold <= 0;
      end else if (hold != 0) begin
         pop <= 1'b0;
         hold <= hold - 1;
      end else begin
         pop <= 1'b1;
         if ($urandom_range(0, 5) == 0) hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (residuals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: residual %h count %0d converged %0b",
                        rsp_residual_squared, rsp_sweep_count, rsp_converged);
         end else begin
            want = residuals_due.pop_front();
            if (rsp_residual_squared !== want.residual_squared ||
                rsp_sweep_count !== want.sweep_count ||
                rsp_converged !== want.converged) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: residual %h/%h count %0d/%0d converged %0b/%0b",
                           want.residual_squared, rsp_residual_squared,
                           want.sweep_count, rsp_sweep_count,
                           want.converged, rsp_converged);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int                            random_beats;
      int                            sweeps_in_phase;
      int                            len;
      int                            amp;
      int                            v;
      logic [COUNT_BITS-1:0]         lim;
      logic [CSR_DATA_BITS-1:0]      data;
      logic signed [SAMPLE_BITS-1:0] s;

      plan = '{
         '{ROW_BEAT, OP_SAMPLE,  24'h7FFFFF, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h800000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h000000, 1'b1, 1'b1, '{SUM_ALL_ONES, 20'd1, 1'b0},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h800000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h7FFFFF, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h000005, 1'b1, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_RESTART, 24'hFFFFFF, 1'b1, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h00007B, 1'b1, 1'b1, '{SUM_ALL_ONES, 20'd1, 1'b0},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h00007B, 1'b1, 1'b1, '{64'd0, 20'd2, 1'b0},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd1},
         '{ROW_BEAT, OP_SAMPLE,  24'h00007B, 1'b1, 1'b1, '{64'd0, 20'd3, 1'b1},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'h00007C, 1'b1, 1'b1, '{64'd1, 20'd4, 1'b0},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, '1},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_SWEEP_LIMIT, 64'd5},
         '{ROW_BEAT, OP_SAMPLE,  24'h000000, 1'b1, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_RESTART, 24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_SWEEP_LIMIT,
           64'hFFFF_FFFF_FFF0_0001},
         '{ROW_BEAT, OP_SAMPLE,  24'hFFFFFF, 1'b1, 1'b1, '{SUM_ALL_ONES, 20'd1, 1'b1},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_SWEEP_LIMIT,
           64'hABC0_0000_0000_0000},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_SAMPLE,  24'hFFFFFF, 1'b1, 1'b1, '{64'd0, 20'd2, 1'b1},
           CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_CSR,  OP_SAMPLE,  24'h000000, 1'b0, 1'b0, NO_RESULT, CSR_SWEEP_LIMIT,
           64'h000F_FFFF},
         '{ROW_BEAT, OP_SAMPLE,  24'h7FFFFF, 1'b1, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0},
         '{ROW_BEAT, OP_RESTART, 24'h123456, 1'b1, 1'b0, NO_RESULT, CSR_TOLERANCE_SQUARED, 64'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_and_settle();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_beat(plan[i].op, plan[i].sample, plan[i].last, plan[i].typed, plan[i].want);
         end
      end

      // random phases of sweeps; registers change only once the block has gone quiet
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         drain_and_settle();
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0:       data = '0;
            1:       data = '1;
            2:       data = 64'($urandom_range(0, 64));
            3:       data = {$urandom, $urandom};
            default: data = (64'd1 << $urandom_range(0, 52)) + $urandom_range(0, 1000);
         endcase
         write_reg(CSR_TOLERANCE_SQUARED, data);
         case ($urandom_range(0, 7))
            0:       lim = '0;
            1:       lim = 20'd1;
            2, 3:    lim = COUNT_BITS'($urandom_range(2, 8));
            4:       lim = COUNT_MAX;
            default: lim = COUNT_BITS'($urandom_range(1, COUNT_MAX));
         endcase
         data = {$urandom, $urandom};
         data[COUNT_BITS-1:0] = lim;
         write_reg(CSR_SWEEP_LIMIT, data);
         if ($urandom_range(0, 2) == 0) begin
            send_beat(OP_RESTART, SAMPLE_BITS'($urandom), 1'($urandom), 1'b0, NO_RESULT);
            random_beats++;
         end
         sweeps_in_phase = $urandom_range(1, 6);
         repeat (sweeps_in_phase) begin
            if (have_prev)
               len = ($urandom_range(0, 9) < 7) ? filled_span : $urandom_range(1, filled_span);
            else begin
               v = $urandom_range(0, 99);
               len = (v < 85) ? $urandom_range(1, 24) :
                     (v < 97) ? $urandom_range(25, 200) : $urandom_range(201, 600);
            end
            v = $urandom_range(0, 99);
            amp = (v < 10) ? 0 : (v < 45) ? $urandom_range(1, 4) :
                  (v < 75) ? $urandom_range(5, 300) :
                  (v < 90) ? $urandom_range(301, 200000) : -1;
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 79) == 0) begin
                  send_beat(OP_RESTART, SAMPLE_BITS'($urandom), 1'($urandom), 1'b0, NO_RESULT);
                  random_beats++;
               end
               if (have_prev && amp >= 0) begin
                  v = int'(stored_grid[grid_pos]) + int'($urandom_range(0, 2 * amp)) - amp;
                  if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
                  if (v < int'(SAMPLE_MIN)) v = int'(SAMPLE_MIN);
                  s = SAMPLE_BITS'(v);
               end else if ($urandom_range(0, 1) == 0) begin
                  s = SAMPLE_BITS'($urandom);
               end else begin
                  s = SAMPLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
               end
               send_beat(OP_SAMPLE, s, k == len - 1, 1'b0, NO_RESULT);
               random_beats++;
            end
         end
      end

      // full-scale swings: fill a span at one extreme, then swing every point across the range
      drain_and_settle();
      calm = 1'b0;
      write_reg(CSR_TOLERANCE_SQUARED, '1);
      write_reg(CSR_SWEEP_LIMIT, 64'(COUNT_MAX));
      send_beat(OP_RESTART, '0, 1'b0, 1'b0, NO_RESULT);
      for (int k = 0; k < SWING_POINTS; k++)
         send_beat(OP_SAMPLE, SAMPLE_MIN, k == SWING_POINTS - 1, 1'b0, NO_RESULT);
      for (int k = 0; k < SWING_POINTS; k++) begin
         s = stored_grid[grid_pos][SAMPLE_BITS-1] ? SAMPLE_MAX : SAMPLE_MIN;
         send_beat(OP_SAMPLE, s, k == SWING_POINTS - 1, 1'b0, NO_RESULT);
      end

      drain_and_settle();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
